FILE: rtl/nine_slice_texture_mapper_assert.svh
// Assertion macros used by the checker file of the nine-slice mapper.
// Each macro expands to one labeled concurrent assertion, reset-qualified.
`ifndef NINE_SLICE_TEXTURE_MAPPER_ASSERT_SVH
`define NINE_SLICE_TEXTURE_MAPPER_ASSERT_SVH

// same-cycle implication
`define NSTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define NSTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/nstm_pkg.sv
// ----------------------------------------------------------------------------
// nstm_pkg
// Shared codes of the nine-slice texture mapper: register indexes, slice
// codes along one axis and the highest segment number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nstm_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_LEFT   = 3'd0,
    REG_MIDW   = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_TOP    = 3'd3,
    REG_MIDH   = 3'd4,
    REG_BOTTOM = 3'd5,
    REG_BOXW   = 3'd6,
    REG_BOXH   = 3'd7
  } cfg_reg_t;

  localparam int CFG_IDX_BITS = 3;

  // slice along one axis
  localparam logic [1:0] SEL_FIRST = 2'd0;
  localparam logic [1:0] SEL_MID   = 2'd1;
  localparam logic [1:0] SEL_LAST  = 2'd2;

  // bottom-right segment
  localparam logic [3:0] SEG_LAST = 4'd8;

endpackage

`default_nettype wire

FILE: rtl/nine_slice_texture_mapper.sv
// ----------------------------------------------------------------------------
// nine_slice_texture_mapper
// Maps an output pixel of a nine-slice scaled box to a source segment and
// the coordinate inside it; stretched spans use an exact integer quotient.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------
//  in       | in_valid/stall   | in_out_x, in_out_y
//  out      | out_valid/stall  | out_segment, out_src_x, out_src_y,
//           |                  | out_in_range
//  cfg      | cfg_we           | cfg_index, cfg_data
//
// One word per clock while the output is not stalled; the restoring divider
// resolves one quotient bit per pipeline stage.
// rst_n (synchronous) clears the valid bits and the configuration registers to zero.
// A stalled output freezes the whole pipeline; bubbles still drain into the
// output register, so in_stall is only raised while a word waits there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nine_slice_texture_mapper
  import nstm_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input words
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [COORD_BITS-1:0]   in_out_x,
  input  wire logic [COORD_BITS-1:0]   in_out_y,
  // result words
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [3:0]                   out_segment,
  output logic [COORD_BITS-1:0]        out_src_x,
  output logic [COORD_BITS-1:0]        out_src_y,
  output logic                         out_in_range,
  // configuration
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [COORD_BITS-1:0]   cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int NSTG = CB + 2;   // front, multiply, one stage per quotient bit

  // per-axis pipeline payload
  typedef struct packed {
    logic [1:0]      sel;   // slice code
    logic [CB-1:0]   lin;   // local coordinate for unscaled slices
    logic [CB-1:0]   span;  // stretch divisor
    logic [2*CB-1:0] work;  // {remainder, dividend low / quotient}
  } ax_t;

  typedef struct packed {
    logic rng;
    ax_t  ax;
    ax_t  ay;
  } stg_t;

  // configuration registers
  logic [CB-1:0] left_r, midw_r, right_r, top_r, midh_r, bottom_r, boxw_r, boxh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      midw_r   <= '0;
      right_r  <= '0;
      top_r    <= '0;
      midh_r   <= '0;
      bottom_r <= '0;
      boxw_r   <= '0;
      boxh_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT:   left_r   <= cfg_data;
        REG_MIDW:   midw_r   <= cfg_data;
        REG_RIGHT:  right_r  <= cfg_data;
        REG_TOP:    top_r    <= cfg_data;
        REG_MIDH:   midh_r   <= cfg_data;
        REG_BOTTOM: bottom_r <= cfg_data;
        REG_BOXW:   boxw_r   <= cfg_data;
        REG_BOXH:   boxh_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // slice select for one axis; box smaller than first plus last falls through
  function automatic ax_t map_front(logic [CB-1:0] pos, logic [CB-1:0] first,
                                    logic [CB-1:0] last, logic [CB-1:0] size);
    logic [CB:0] sum;
    ax_t         r;
    sum    = {1'b0, pos} + {1'b0, last};
    r.span = size - first - last;
    r.work = {{CB{1'b0}}, pos - first};
    if (pos < first) begin
      r.sel = SEL_FIRST;
      r.lin = pos;
    end else if (sum < {1'b0, size}) begin
      r.sel = SEL_MID;
      r.lin = '0;
    end else begin
      r.sel = SEL_LAST;
      r.lin = CB'(sum - {1'b0, size});
    end
    return r;
  endfunction

  // product (pos - first) * middle
  function automatic ax_t mul_step(ax_t a, logic [CB-1:0] mid);
    ax_t r;
    r      = a;
    r.work = (2*CB)'(a.work[CB-1:0]) * (2*CB)'(mid);
    return r;
  endfunction

  // one restoring division step: quotient bit shifts in at the bottom
  function automatic ax_t div_step(ax_t a);
    logic [CB:0] trial;
    logic        q;
    ax_t         r;
    r     = a;
    trial = {a.work[2*CB-1:CB], a.work[CB-1]};
    q     = (trial >= {1'b0, a.span});
    if (q) begin
      r.work[2*CB-1:CB] = CB'(trial - {1'b0, a.span});
    end else begin
      r.work[2*CB-1:CB] = trial[CB-1:0];
    end
    r.work[CB-1:0] = {a.work[CB-2:0], q};
    return r;
  endfunction

  // pipeline control: everything moves unless a result waits at the output
  logic advance;
  logic out_valid_r;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  stg_t stg_r   [NSTG];
  stg_t stg_nxt [NSTG];
  logic vld_r   [NSTG];

  // front stage: range test and slice select
  always_comb begin
    stg_nxt[0].rng = (in_out_x < boxw_r) && (in_out_y < boxh_r);
    stg_nxt[0].ax  = map_front(in_out_x, left_r, right_r, boxw_r);
    stg_nxt[0].ay  = map_front(in_out_y, top_r, bottom_r, boxh_r);
  end

  // multiply stage
  always_comb begin
    stg_nxt[1].rng = stg_r[0].rng;
    stg_nxt[1].ax  = mul_step(stg_r[0].ax, midw_r);
    stg_nxt[1].ay  = mul_step(stg_r[0].ay, midh_r);
  end

  // divider stages
  for (genvar k = 2; k < NSTG; k++) begin : g_div
    always_comb begin
      stg_nxt[k].rng = stg_r[k-1].rng;
      stg_nxt[k].ax  = div_step(stg_r[k-1].ax);
      stg_nxt[k].ay  = div_step(stg_r[k-1].ay);
    end
  end

  // stage registers and their valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) vld_r[i] <= 1'b0;
    end else if (advance) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < NSTG; i++) stg_r[i] <= stg_nxt[i];
    end
  end

  // output formatting
  stg_t          fin;
  logic [3:0]    seg_nxt;
  logic [CB-1:0] sx_nxt, sy_nxt;

  always_comb begin
    fin     = stg_r[NSTG-1];
    seg_nxt = ({2'b00, fin.ay.sel} << 1) + {2'b00, fin.ay.sel} + {2'b00, fin.ax.sel};
    sx_nxt  = (fin.ax.sel == SEL_MID) ? fin.ax.work[CB-1:0] : fin.ax.lin;
    sy_nxt  = (fin.ay.sel == SEL_MID) ? fin.ay.work[CB-1:0] : fin.ay.lin;
    if (!fin.rng) begin
      seg_nxt = '0;
      sx_nxt  = '0;
      sy_nxt  = '0;
    end
  end

  logic [3:0]    seg_r;
  logic [CB-1:0] sx_r, sy_r;
  logic          rng_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      seg_r <= seg_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      rng_r <= fin.rng;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_segment  = seg_r;
  assign out_src_x    = sx_r;
  assign out_src_y    = sy_r;
  assign out_in_range = rng_r;

endmodule

`default_nettype wire

FILE: rtl/nstm_checker.sv
// ----------------------------------------------------------------------------
// nstm_checker
// Port-level checks of the nine-slice mapper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "nine_slice_texture_mapper_assert.svh"

module nstm_checker
  import nstm_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [3:0]            out_segment,
  input wire logic [COORD_BITS-1:0] out_src_x,
  input wire logic [COORD_BITS-1:0] out_src_y,
  input wire logic                  out_in_range
);

  // a stalled result word holds
  `NSTM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_segment) && $stable(out_src_x) && $stable(out_src_y) && $stable(out_in_range))

  // a waiting result blocks the input side
  `NSTM_ASSERT_IMP(a_backpressure, clk, rst_n, out_valid && out_stall, in_stall)

  // outside the box every field reads zero
  `NSTM_ASSERT_IMP(a_out_of_box, clk, rst_n, out_valid && !out_in_range, out_segment == 4'd0 && out_src_x == '0 && out_src_y == '0)

  // segment stays within the 3 by 3 grid
  `NSTM_ASSERT_IMP(a_seg_range, clk, rst_n, out_valid, out_segment <= SEG_LAST)

endmodule

bind nine_slice_texture_mapper nstm_checker #(.COORD_BITS(COORD_BITS)) u_nstm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_segment  (out_segment),
  .out_src_x    (out_src_x),
  .out_src_y    (out_src_y),
  .out_in_range (out_in_range)
);

`default_nettype wire

FILE: tb/nine_slice_checker.sv
// ----------------------------------------------------------------------------
// nine_slice_checker
// Watches the input, result and register ports of the nine-slice mapper. It
// keeps its own copy of the registers, predicts the mapped pixel for each
// accepted input word and compares each accepted result word, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nine_slice_checker
  import nstm_pkg::*;
#(
  parameter int W = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_stall,
  input  wire logic [W-1:0]            in_out_x,
  input  wire logic [W-1:0]            in_out_y,
  input  wire logic                    out_valid,
  input  wire logic                    out_stall,
  input  wire logic [3:0]              out_segment,
  input  wire logic [W-1:0]            out_src_x,
  input  wire logic [W-1:0]            out_src_y,
  input  wire logic                    out_in_range,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [W-1:0]            cfg_data,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic [3:0]   segment;
    logic [W-1:0] src_x;
    logic [W-1:0] src_y;
    logic         in_range;
  } mapped_px_t;

  logic [W-1:0] box_regs [0:7];
  mapped_px_t   mapped_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // one axis: corner span copied, middle span stretched, last span copied
  function automatic void map_axis(input logic [W-1:0] pos, input logic [W-1:0] first,
                                   input logic [W-1:0] middle, input logic [W-1:0] last,
                                   input logic [W-1:0] size, output logic [1:0] sel,
                                   output logic [W-1:0] loc);
    logic [2*W:0] p_w, f_w, m_w, l_w, s_w, span, prod;
    p_w = pos;
    f_w = first;
    m_w = middle;
    l_w = last;
    s_w = size;
    if (p_w < f_w) begin
      sel = SEL_FIRST;
      loc = pos;
    end else if (p_w + l_w < s_w) begin
      span = s_w - f_w - l_w;
      prod = (p_w - f_w) * m_w;
      sel  = SEL_MID;
      loc  = W'(prod / span);
    end else begin
      sel = SEL_LAST;
      loc = W'(p_w + l_w - s_w);
    end
  endfunction

  function automatic mapped_px_t map_pixel(input logic [W-1:0] x, input logic [W-1:0] y);
    mapped_px_t px;
    logic [1:0] col, row;
    logic [W-1:0] lx, ly;
    px = '0;
    if (x < box_regs[REG_BOXW] && y < box_regs[REG_BOXH]) begin
      map_axis(x, box_regs[REG_LEFT], box_regs[REG_MIDW], box_regs[REG_RIGHT],
               box_regs[REG_BOXW], col, lx);
      map_axis(y, box_regs[REG_TOP], box_regs[REG_MIDH], box_regs[REG_BOTTOM],
               box_regs[REG_BOXH], row, ly);
      px.segment  = 4'(row) * 4'd3 + 4'(col);
      px.src_x    = lx;
      px.src_y    = ly;
      px.in_range = 1'b1;
    end
    return px;
  endfunction

  always @(posedge clk) begin
    mapped_px_t exp_px;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) box_regs[i] = '0;
      mapped_q.delete();
    end else begin
      // register writes must only land while the pipeline is empty; nothing here enforces it
      if (cfg_we) box_regs[cfg_index] = cfg_data;

      // result word against the oldest prediction
      if (out_valid && !out_stall) begin
        if (mapped_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word: seg=%0d x=%0d y=%0d in=%0b",
                     out_segment, out_src_x, out_src_y, out_in_range);
          fail_count++;
        end else begin
          exp_px = mapped_q.pop_front();
          if (out_segment !== exp_px.segment || out_src_x !== exp_px.src_x ||
              out_src_y !== exp_px.src_y || out_in_range !== exp_px.in_range) begin
            if (fail_count < 10)
              $display("mismatch: exp seg=%0d x=%0d y=%0d in=%0b, got seg=%0d x=%0d y=%0d in=%0b",
                       exp_px.segment, exp_px.src_x, exp_px.src_y, exp_px.in_range,
                       out_segment, out_src_x, out_src_y, out_in_range);
            fail_count++;
          end
        end
      end

      // new coordinate word
      if (in_valid && !in_stall) mapped_q.push_back(map_pixel(in_out_x, in_out_y));
    end
    pending = mapped_q.size();
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the nine-slice mapper with directed boundary pixels and random
// pixel streams over a series of box settings, with random gaps on the input
// and random stalls on the output; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import nstm_pkg::*;
();

  localparam int COORD_W         = 12;
  localparam int LATENCY         = COORD_W + 3;
  localparam int RAND_PHASES     = 9;
  localparam int WORDS_PER_PHASE = 150;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic [COORD_W-1:0]      in_out_x  = '0;
  logic [COORD_W-1:0]      in_out_y  = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [3:0]              out_segment;
  logic [COORD_W-1:0]      out_src_x;
  logic [COORD_W-1:0]      out_src_y;
  logic                    out_in_range;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COORD_W-1:0]      cfg_data  = '0;

  int fail_count;
  int pending;
  bit no_gaps = 1'b0;
  logic [COORD_W-1:0] cur_cfg [0:7];

  nine_slice_texture_mapper #(.COORD_BITS(COORD_W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_out_x(in_out_x), .in_out_y(in_out_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_segment(out_segment),
    .out_src_x(out_src_x), .out_src_y(out_src_y), .out_in_range(out_in_range),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  nine_slice_checker #(.W(COORD_W)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_out_x(in_out_x), .in_out_y(in_out_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_segment(out_segment),
    .out_src_x(out_src_x), .out_src_y(out_src_y), .out_in_range(out_in_range),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #4 clk = ~clk;

  // hard stop
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stall before each word
  initial begin
    int stall_cycles;
    wait (rst_n);
    forever begin
      @(negedge clk);
      stall_cycles = no_gaps ? 0 : $urandom_range(0, 17);
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [COORD_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    cur_cfg[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_box(input int l, input int mw, input int r, input int bw,
                         input int t, input int mh, input int b, input int bh);
    write_reg(REG_LEFT, COORD_W'(l));
    write_reg(REG_MIDW, COORD_W'(mw));
    write_reg(REG_RIGHT, COORD_W'(r));
    write_reg(REG_BOXW, COORD_W'(bw));
    write_reg(REG_TOP, COORD_W'(t));
    write_reg(REG_MIDH, COORD_W'(mh));
    write_reg(REG_BOTTOM, COORD_W'(b));
    write_reg(REG_BOXH, COORD_W'(bh));
  endtask

  // random geometry for one axis; sometimes first + last overflows the box
  task automatic random_axis(input cfg_reg_t r_first, input cfg_reg_t r_mid,
                             input cfg_reg_t r_last, input cfg_reg_t r_size);
    int kind, sz, f, l;
    kind = $urandom_range(0, 3);
    sz   = (kind == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 200);
    f    = (kind == 3) ? $urandom_range(0, sz) : $urandom_range(0, sz / 2);
    l    = (kind == 3) ? $urandom_range(0, sz) : $urandom_range(0, sz / 2);
    write_reg(r_first, COORD_W'(f));
    write_reg(r_mid, COORD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                           : $urandom_range(0, 300)));
    write_reg(r_last, COORD_W'(l));
    write_reg(r_size, COORD_W'(sz));
  endtask

  // coordinate mostly inside the box, some on span edges, some anywhere
  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] first,
                                                    input logic [COORD_W-1:0] last,
                                                    input logic [COORD_W-1:0] size);
    logic [COORD_W-1:0] c;
    case ($urandom_range(0, 9))
      0: c = COORD_W'($urandom_range(0, 4095));
      1: begin
        case ($urandom_range(0, 7))
          0: c = first - 1'b1;
          1: c = first;
          2: c = size - last - 1'b1;
          3: c = size - last;
          4: c = size - 1'b1;
          5: c = size;
          6: c = '0;
          default: c = '1;
        endcase
      end
      default: c = (size == 0) ? COORD_W'($urandom_range(0, 4095))
                               : COORD_W'($urandom_range(0, size - 1));
    endcase
    return c;
  endfunction

  // one coordinate word after a random gap
  task automatic send_word(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_out_x <= x;
    in_out_y <= y;
    do @(posedge clk); while (in_stall);
  endtask

  // drain the pipeline before touching registers
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) cur_cfg[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero-size box straight out of reset
    send_word(12'd0, 12'd0);
    send_word(12'hFFF, 12'hFFF);
    wait_idle();

    // ordinary box: span edges, outside edges, alternating bit patterns
    set_box(8, 32, 8, 100, 5, 20, 6, 60);
    send_word(12'd0, 12'd0);
    send_word(12'd7, 12'd4);
    send_word(12'd8, 12'd5);
    send_word(12'd91, 12'd53);
    send_word(12'd92, 12'd54);
    send_word(12'd99, 12'd59);
    send_word(12'd100, 12'd0);
    send_word(12'd0, 12'd60);
    send_word(12'd50, 12'd30);
    send_word(12'hFFF, 12'd0);
    send_word(12'hAAA, 12'h555);
    send_word(12'h555, 12'hAAA);
    wait_idle();

    // every register at its maximum
    set_box(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    send_word(12'd4094, 12'd0);
    send_word(12'd2048, 12'd4094);
    wait_idle();

    // full-size middle span, no corners
    set_box(0, 4095, 0, 4095, 0, 4095, 0, 4095);
    send_word(12'd4094, 12'd4094);
    send_word(12'd0, 12'd1365);
    wait_idle();

    // box narrower than its corners on x, empty middle span on y
    set_box(50, 10, 60, 80, 10, 7, 10, 20);
    send_word(12'd49, 12'd9);
    send_word(12'd50, 12'd10);
    send_word(12'd79, 12'd19);
    wait_idle();

    // random streams, one box setting per phase
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: set_box(8, 32, 8, 100, 5, 20, 6, 60);
        1: set_box(0, 4095, 0, 4095, 0, 4095, 0, 4095);
        2: set_box(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
        3: set_box(50, 10, 60, 80, 10, 7, 10, 20);
        default: begin
          random_axis(REG_LEFT, REG_MIDW, REG_RIGHT, REG_BOXW);
          random_axis(REG_TOP, REG_MIDH, REG_BOTTOM, REG_BOXH);
        end
      endcase
      no_gaps = (p % 3 == 2);
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        send_word(pick_coord(cur_cfg[REG_LEFT], cur_cfg[REG_RIGHT], cur_cfg[REG_BOXW]),
                  pick_coord(cur_cfg[REG_TOP], cur_cfg[REG_BOTTOM], cur_cfg[REG_BOXH]));
      wait_idle();
    end
    no_gaps = 1'b0;

    repeat (LATENCY + 5) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
